>>> sv/lpd_pkg.sv
package lpd_pkg;

  localparam logic [31:0] MaxLengthReset = 32'd1048576;

  typedef enum logic [1:0] {
    PhHeader  = 2'd0,
    PhBody    = 2'd1,
    PhDiscard = 2'd2
  } phase_e;

  typedef enum logic {
    ReqByte  = 1'b0,
    ReqClose = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    StBody  = 2'd0,
    StError = 2'd1,
    StAbort = 2'd2
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [7:0]  body_byte;
    logic        last;
    logic [31:0] frame_length;
  } result_t;

endpackage

>>> sv/lpd_if.sv
interface lpd_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

interface lpd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  body_byte;
  logic        last;
  logic [31:0] frame_length;

  modport source (output valid, output status, output body_byte, output last,
                  output frame_length, input ready);
  modport sink (input valid, input status, input body_byte, input last,
                input frame_length, output ready);
endinterface

>>> sv/length_prefix_deframer_top.sv
// path: the result of a transferred byte or disconnect is written to the queue,
// then loaded into the output register, from which it is offered
// throughput: one item per cycle if the queue is not full, set by the header/body update
// a 2-entry queue and the output register let input and output stall independently
// reset: asynchronous active low; header reception, counters cleared,
// max_length back to 1048576, queue and output empty
module length_prefix_deframer_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  lpd_in_if.sink      req_i,
  lpd_out_if.source   res_o
);
  import lpd_pkg::*;

  logic    push, q_full, q_empty, pop;
  result_t push_data, q_data;

  lpd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  lpd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_data)
  );

  lpd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_data),
    .pop_o     (pop),
    .res_o     (res_o)
  );

endmodule

>>> sv/lpd_front.sv
module lpd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [31:0]     cfg_wdata_i,
  lpd_in_if.sink          req_i,
  input  logic            q_full_i,
  output logic            push_o,
  output lpd_pkg::result_t push_data_o
);
  import lpd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [1:0]  hdr_cnt_q, hdr_cnt_d;
  logic [31:0] length_q, length_d;
  logic [31:0] body_cnt_q, body_cnt_d;
  logic [31:0] max_len_q;

  logic        accept;
  logic        is_close;
  logic [31:0] len_shift;
  logic        len_bad;
  logic [31:0] body_inc;
  logic        body_fin;

  assign req_i.ready = !q_full_i;
  assign accept      = req_i.valid && req_i.ready;
  assign is_close    = (req_i.req_type == ReqClose);
  assign len_shift   = {length_q[23:0], req_i.rx_byte};
  assign len_bad     = (len_shift == 32'd0) || (len_shift > max_len_q);
  assign body_inc    = body_cnt_q + 32'd1;
  assign body_fin    = (body_inc == length_q);

  // next state
  always_comb begin
    phase_d    = phase_q;
    hdr_cnt_d  = hdr_cnt_q;
    length_d   = length_q;
    body_cnt_d = body_cnt_q;
    if (accept) begin
      if (is_close) begin
        phase_d    = PhHeader;
        hdr_cnt_d  = 2'd0;
        length_d   = 32'd0;
        body_cnt_d = 32'd0;
      end else begin
        unique case (phase_q)
          PhHeader: begin
            length_d  = len_shift;
            hdr_cnt_d = hdr_cnt_q + 2'd1;
            if (hdr_cnt_q == 2'd3) begin
              phase_d    = len_bad ? PhDiscard : PhBody;
              body_cnt_d = 32'd0;
            end
          end
          PhBody: begin
            body_cnt_d = body_inc;
            if (body_fin) begin
              phase_d = PhDiscard;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // result for the queue
  always_comb begin
    push_o                   = 1'b0;
    push_data_o.status       = StBody;
    push_data_o.body_byte    = 8'd0;
    push_data_o.last         = 1'b0;
    push_data_o.frame_length = 32'd0;
    if (accept) begin
      if (is_close) begin
        unique case (phase_q)
          PhHeader: begin
            push_o             = (hdr_cnt_q != 2'd0);
            push_data_o.status = StAbort;
          end
          PhBody: begin
            push_o                   = 1'b1;
            push_data_o.status       = StAbort;
            push_data_o.frame_length = length_q;
          end
          default: ;
        endcase
      end else begin
        unique case (phase_q)
          PhHeader: begin
            push_o                   = (hdr_cnt_q == 2'd3) && len_bad;
            push_data_o.status       = StError;
            push_data_o.frame_length = len_shift;
          end
          PhBody: begin
            push_o                   = 1'b1;
            push_data_o.body_byte    = req_i.rx_byte;
            push_data_o.last         = body_fin;
            push_data_o.frame_length = length_q;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHeader;
      hdr_cnt_q  <= 2'd0;
      length_q   <= 32'd0;
      body_cnt_q <= 32'd0;
      max_len_q  <= MaxLengthReset;
    end else begin
      phase_q    <= phase_d;
      hdr_cnt_q  <= hdr_cnt_d;
      length_q   <= length_d;
      body_cnt_q <= body_cnt_d;
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
    end
  end

endmodule

>>> sv/lpd_fifo.sv
module lpd_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lpd_pkg::result_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output lpd_pkg::result_t pop_data_o
);
  import lpd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  result_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == CntFull);
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> sv/lpd_back.sv
module lpd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  lpd_pkg::result_t q_data_i,
  output logic             pop_o,
  lpd_out_if.source        res_o
);
  import lpd_pkg::*;

  logic    vld_q;
  result_t res_q;
  logic    load;

  // output register refills when empty or when its transfer completes
  assign load  = !vld_q || res_o.ready;
  assign pop_o = load && !q_empty_i;

  assign res_o.valid        = vld_q;
  assign res_o.status       = res_q.status;
  assign res_o.body_byte    = res_q.body_byte;
  assign res_o.last         = res_q.last;
  assign res_o.frame_length = res_q.frame_length;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load) begin
      vld_q <= !q_empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= q_data_i;
    end
  end

endmodule
